// ===== src/mads_pkg.sv =====
// ----------------------------------------------------------------------------
// mads_pkg: shared constants for the moving-average deadband smoother
// Widths and reset values used by the smoother and its port checker.
// ----------------------------------------------------------------------------
package mads_pkg;

    // Number of samples in the averaging window.
    localparam int WINDOW_DEPTH = 8;

    // Width of one level sample and of the held level.
    localparam int LEVEL_W   = 8;
    localparam int LEVEL_MAX = (2 ** LEVEL_W) - 1;

    // Ring slot index, fill count (holds 0..WINDOW_DEPTH) and running sum.
    localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W   = LEVEL_W + $clog2(WINDOW_DEPTH);

    // Divider partial remainder and step counter.
    localparam int REM_W  = COUNT_W + 1;
    localparam int ITER_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    // Width of the packed output data bus (whole bytes).
    localparam int TDATA_W = ((LEVEL_W + 7) / 8) * 8;

    // Reset value of the deadband register.
    localparam logic [LEVEL_W-1:0] MIN_CHANGE_RESET = LEVEL_W'(2);

endpackage

// ===== src/moving_average_deadband_smoother_unit.sv =====
// ----------------------------------------------------------------------------
// moving_average_deadband_smoother_unit: level smoother with deadband
// Averages the most recent level samples and holds the average steady
// against changes smaller than a programmable minimum.
// ----------------------------------------------------------------------------
// Each accepted item carries one 8-bit level sample. The sample replaces the
// oldest entry of an eight-entry ring, the running sum is updated, and the sum
// is divided by the number of samples seen so far (at most eight), truncating.
// While the ring is still filling, that average always becomes the held level.
// Once the ring is full, an average that differs from the held level by less
// than min_change is dropped and the held level stays. Every input item
// produces exactly one result item carrying the held level and a flag that is
// set when the held level changed. The block handles one item at a time: after
// an input item is accepted, s_tready stays low while the restoring divider,
// which retires one quotient bit per cycle, works through the SUM_W (11) bits
// of the sum, and while the deadband decision is made and the result is loaded
// into the output register. The output register lets the next item be
// accepted while the previous result still waits on m_tready; the decision
// step waits only if the output register is still full. After reset the ring
// reads as all zeros without a clearing pass, and min_change is 2.
// ----------------------------------------------------------------------------
module moving_average_deadband_smoother_unit (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Deadband register write port.
    input  logic                                cfg_wr_en,
    input  logic [mads_pkg::LEVEL_W-1:0]        cfg_wr_data,   // min_change

    // Sample input channel.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mads_pkg::TDATA_W-1:0]        s_tdata,       // [7:0] sample_level

    // Result channel.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mads_pkg::TDATA_W-1:0]        m_tdata,       // [7:0] held_level
    output logic                                m_tuser        // [0] level_changed
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    // Sample ring. Slots at or beyond the fill count were never written and
    // are treated as zero, so the ring itself needs no reset.
    logic [mads_pkg::LEVEL_W-1:0] ring_mem [mads_pkg::WINDOW_DEPTH];

    state_t                          state_reg,      state_next;
    logic [mads_pkg::SLOT_W-1:0]     slot_reg,       slot_next;
    logic [mads_pkg::COUNT_W-1:0]    count_reg,      count_next;
    logic [mads_pkg::SUM_W-1:0]      sum_reg,        sum_next;
    logic [mads_pkg::LEVEL_W-1:0]    level_reg,      level_next;
    logic [mads_pkg::LEVEL_W-1:0]    min_change_reg, min_change_next;
    logic [mads_pkg::SUM_W-1:0]      quot_reg,       quot_next;
    logic [mads_pkg::REM_W-1:0]      rem_reg,        rem_next;
    logic [mads_pkg::ITER_W-1:0]     iter_reg,       iter_next;
    logic                            m_valid_reg,    m_valid_next;
    logic [mads_pkg::LEVEL_W-1:0]    m_level_reg,    m_level_next;
    logic                            m_changed_reg,  m_changed_next;
    logic [mads_pkg::LEVEL_W-1:0]    ring_rd_reg;

    logic                            in_accept;
    logic                            ring_full;
    logic [mads_pkg::LEVEL_W-1:0]    sample;
    logic [mads_pkg::LEVEL_W-1:0]    old_entry;
    logic [mads_pkg::SUM_W-1:0]      sum_update;

    logic [mads_pkg::REM_W-1:0]      div_shifted;
    logic [mads_pkg::REM_W-1:0]      div_divisor;
    logic                            div_ge;

    logic [mads_pkg::LEVEL_W-1:0]    avg;
    logic [mads_pkg::LEVEL_W-1:0]    diff;
    logic                            take_avg;
    logic                            out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign sample    = s_tdata[mads_pkg::LEVEL_W-1:0];

    assign ring_full = (count_reg == mads_pkg::COUNT_W'(mads_pkg::WINDOW_DEPTH));

    // The slot being overwritten only holds data once the ring has wrapped.
    // The registered ring read has long settled on the current slot by the
    // time the next item can be accepted.
    assign old_entry  = ring_full ? ring_rd_reg : '0;
    assign sum_update = sum_reg - mads_pkg::SUM_W'(old_entry)
                                + mads_pkg::SUM_W'(sample);

    // One step of the restoring divider: bring down the next dividend bit and
    // subtract the fill count if it fits.
    assign div_shifted = {rem_reg[mads_pkg::REM_W-2:0], quot_reg[mads_pkg::SUM_W-1]};
    assign div_divisor = {1'b0, count_reg};
    assign div_ge      = (div_shifted >= div_divisor);

    // Deadband decision on the finished quotient.
    always_comb begin
        if (quot_reg > mads_pkg::SUM_W'(mads_pkg::LEVEL_MAX)) begin
            avg = mads_pkg::LEVEL_W'(mads_pkg::LEVEL_MAX);
        end else begin
            avg = quot_reg[mads_pkg::LEVEL_W-1:0];
        end
        if (avg >= level_reg) begin
            diff = avg - level_reg;
        end else begin
            diff = level_reg - avg;
        end
        take_avg = !ring_full || (diff >= min_change_reg);
    end

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        level_next      = level_reg;
        min_change_next = min_change_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        iter_next       = iter_reg;
        m_valid_next    = m_valid_reg;
        m_level_next    = m_level_reg;
        m_changed_next  = m_changed_reg;

        if (cfg_wr_en) begin
            min_change_next = cfg_wr_data;
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    sum_next  = sum_update;
                    quot_next = sum_update;
                    rem_next  = '0;
                    iter_next = '0;
                    if (slot_reg == mads_pkg::SLOT_W'(mads_pkg::WINDOW_DEPTH - 1)) begin
                        slot_next = '0;
                    end else begin
                        slot_next = slot_reg + 1'b1;
                    end
                    if (!ring_full) begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_ge) begin
                    rem_next = div_shifted - div_divisor;
                end else begin
                    rem_next = div_shifted;
                end
                quot_next = {quot_reg[mads_pkg::SUM_W-2:0], div_ge};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == mads_pkg::ITER_W'(mads_pkg::SUM_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    if (take_avg) begin
                        level_next = avg;
                    end
                    m_valid_next   = 1'b1;
                    m_level_next   = take_avg ? avg : level_reg;
                    m_changed_next = take_avg && (avg != level_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slot_reg       <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            level_reg      <= '0;
            min_change_reg <= mads_pkg::MIN_CHANGE_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slot_reg       <= slot_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            level_reg      <= level_next;
            min_change_reg <= min_change_next;
            m_valid_reg    <= m_valid_next;
        end
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        iter_reg      <= iter_next;
        m_level_reg   <= m_level_next;
        m_changed_reg <= m_changed_next;
    end

    // Ring write on every accepted sample, and a registered read of the
    // slot that the next sample will overwrite.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            ring_mem[slot_reg] <= sample;
        end
        ring_rd_reg <= ring_mem[slot_reg];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = mads_pkg::TDATA_W'(m_level_reg);
    assign m_tuser  = m_changed_reg;

endmodule

// ===== src/mads_checker.sv =====
// ----------------------------------------------------------------------------
// mads_checker: port-level checks for the deadband smoother
// Watches the top-level handshakes and reset behavior over time.
// ----------------------------------------------------------------------------
module mads_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mads_pkg::TDATA_W-1:0]      m_tdata,
    input logic                              m_tuser
);

    // Reset leaves the block ready for a sample with no result pending.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("block not idle after reset");

    // A result that is not taken keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // After a sample is taken the block is busy with the division.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("sample accepted during division");

    // The held level never reaches past the 8-bit level range in the data word.
    a_tdata_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >> mads_pkg::LEVEL_W) == '0)
        else $error("padding bits of result data not zero");

endmodule

bind moving_average_deadband_smoother_unit mads_checker u_mads_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the moving-average deadband smoother
// Streams level samples into the smoother under random bursts, gaps and
// output stalls, and predicts every held level and change flag in the bench.
// ----------------------------------------------------------------------------
module testbench;

    // One smoothed result: the held level and whether it moved.
    typedef struct packed {
        logic [mads_pkg::LEVEL_W-1:0] level;
        logic                         changed;
    } level_result_t;

    // How the result side accepts items.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC,
        READY_SPARSE
    } ready_mode_t;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_CYCLES = 20;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int REPORT_MAX   = 10;

    // Ports of the block. Every input starts at a known value.
    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           cfg_wr_en   = 1'b0;
    logic [mads_pkg::LEVEL_W-1:0]   cfg_wr_data = '0;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [mads_pkg::TDATA_W-1:0]   s_tdata     = '0;   // [7:0] sample_level
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    logic [mads_pkg::TDATA_W-1:0]   m_tdata;            // [7:0] held_level
    logic                           m_tuser;            // [0] level_changed

    // Samples waiting to be sent, and results the smoother still owes us.
    logic [mads_pkg::LEVEL_W-1:0]   sample_queue[$];
    level_result_t                  pending_levels[$];

    // Handshake bookkeeping. Each handshake counter has exactly one writer.
    int pushed_count   = 0;   // samples queued by the stimulus
    int issued_count   = 0;   // samples put on the bus by the driver
    int accepted_count = 0;   // samples taken by the smoother
    int results_seen   = 0;
    int changes_seen   = 0;
    int error_count    = 0;
    int settings_used  = 0;

    // Pacing knobs, changed by the stimulus between phases.
    int          gap_max      = 0;
    int          burst_max    = 1;
    ready_mode_t ready_mode   = READY_ALWAYS;
    int          stall_period = 32;
    int          stall_len    = 8;

    // Driver and receiver private state.
    int   gap_left   = 0;
    int   burst_left = 0;
    int   stall_tick = 0;
    logic item_busy;

    // Our own copy of the smoother's state.
    logic [mads_pkg::LEVEL_W-1:0] level_ring[mads_pkg::WINDOW_DEPTH];
    logic [mads_pkg::SLOT_W-1:0]  ring_slot;
    logic [mads_pkg::COUNT_W-1:0] ring_fill;
    logic [mads_pkg::SUM_W-1:0]   ring_sum;
    logic [mads_pkg::LEVEL_W-1:0] held_model;
    logic [mads_pkg::LEVEL_W-1:0] deadband_model;

    level_result_t want_result;
    level_result_t got_result;

    moving_average_deadband_smoother_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Applies one sample to the bench copy of the smoother and returns the
    // result it must produce. The sample overwrites the oldest ring entry,
    // the sum is updated, and the truncated average is taken over the
    // samples seen so far. Only a full ring applies the deadband.
    function automatic level_result_t smooth_sample(
        input logic [mads_pkg::LEVEL_W-1:0] sample
    );
        logic [mads_pkg::SUM_W-1:0]   quotient;
        logic [mads_pkg::LEVEL_W-1:0] average;
        logic [mads_pkg::LEVEL_W-1:0] distance;
        logic                         take;
        level_result_t                outcome;
        ring_sum = ring_sum - mads_pkg::SUM_W'(level_ring[ring_slot])
                            + mads_pkg::SUM_W'(sample);
        level_ring[ring_slot] = sample;
        ring_slot = (int'(ring_slot) == mads_pkg::WINDOW_DEPTH - 1) ? '0
                                                                   : ring_slot + 1'b1;
        if (int'(ring_fill) < mads_pkg::WINDOW_DEPTH) begin
            ring_fill = ring_fill + 1'b1;
        end
        quotient = ring_sum / ring_fill;
        average  = (quotient > mads_pkg::SUM_W'(mads_pkg::LEVEL_MAX))
                 ? mads_pkg::LEVEL_W'(mads_pkg::LEVEL_MAX)
                 : quotient[mads_pkg::LEVEL_W-1:0];
        take = 1'b1;
        if (int'(ring_fill) >= mads_pkg::WINDOW_DEPTH) begin
            distance = (average >= held_model) ? average - held_model : held_model - average;
            if (distance < deadband_model) begin
                take = 1'b0;
            end
        end
        outcome.changed = take && (average != held_model);
        if (take) begin
            held_model = average;
        end
        outcome.level = held_model;
        return outcome;
    endfunction

    function automatic void note_mismatch(input string what);
        error_count++;
        if (error_count <= REPORT_MAX) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
    endfunction

    // Monitor: everything is sampled at the rising edge. Accepted samples
    // feed the predictor, register writes update its deadband, and each
    // accepted result is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < mads_pkg::WINDOW_DEPTH; k++) begin
                level_ring[k] = '0;
            end
            ring_slot      = '0;
            ring_fill      = '0;
            ring_sum       = '0;
            held_model     = '0;
            deadband_model = mads_pkg::MIN_CHANGE_RESET;
        end else begin
            if (cfg_wr_en) begin
                deadband_model = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                pending_levels.push_back(smooth_sample(s_tdata[mads_pkg::LEVEL_W-1:0]));
                accepted_count++;
            end
            if (m_tvalid && m_tready) begin
                got_result.level   = m_tdata[mads_pkg::LEVEL_W-1:0];
                got_result.changed = m_tuser;
                results_seen++;
                if (m_tuser === 1'b1) begin
                    changes_seen++;
                end
                if (pending_levels.size() == 0) begin
                    note_mismatch($sformatf("result with nothing expected: level %0d changed %0b",
                                            got_result.level, got_result.changed));
                end else begin
                    want_result = pending_levels.pop_front();
                    if (got_result.level !== want_result.level) begin
                        note_mismatch($sformatf("result %0d held_level expected %0d got %0d",
                                                results_seen, want_result.level,
                                                got_result.level));
                    end
                    if (got_result.changed !== want_result.changed) begin
                        note_mismatch($sformatf("result %0d level_changed expected %0b got %0b",
                                                results_seen, want_result.changed,
                                                got_result.changed));
                    end
                end
            end
        end
    end

    // Driver: inputs change only at the falling edge. An item on the bus
    // stays there until the monitor has counted it as accepted; after that
    // the next one goes out at once inside a burst, or after a random gap.
    always @(negedge aclk) begin
        if (aresetn) begin
            item_busy = s_tvalid && (accepted_count != issued_count);
            if (!item_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (sample_queue.size() > 0) begin
                    s_tdata  <= mads_pkg::TDATA_W'(sample_queue.pop_front());
                    s_tvalid <= 1'b1;
                    issued_count++;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // End of a burst: pick the next burst length and the
                        // pause in front of it.
                        burst_left = $urandom_range(0, burst_max - 1);
                        gap_left   = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: its own stall pattern, also moved at the falling edge.
    // The periodic mode holds m_tready low for a stretch at the start of
    // every period, so long stalls land on every phase of the divider.
    always @(negedge aclk) begin
        stall_tick++;
        case (ready_mode)
            READY_ALWAYS: begin
                m_tready <= 1'b1;
            end
            READY_RANDOM: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            READY_PERIODIC: begin
                m_tready <= ((stall_tick % stall_period) >= stall_len);
            end
            default: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    // Waits until every queued sample has been taken and every result has
    // come back. Conditions are read at the falling edge, after all of the
    // rising-edge bookkeeping has settled.
    task automatic wait_drained();
        @(negedge aclk);
        while (accepted_count != pushed_count || pending_levels.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Writes the deadband register while the smoother is idle. Every sample
    // yields a result, so once nothing is owed the block is quiet; a short
    // settle still covers the output register emptying.
    task automatic write_min_change(input logic [mads_pkg::LEVEL_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        settings_used++;
        @(posedge aclk);
    endtask

    task automatic push_sample(input int value);
        sample_queue.push_back(mads_pkg::LEVEL_W'(value));
        pushed_count++;
    endtask

    // Random level traces built from short segments of different shapes:
    // steady levels with small noise and slow ramps (the cases where the
    // deadband matters), readings in the usual percent range, and some
    // raw noise and rail-to-rail jumps so every sample bit toggles.
    task automatic queue_levels(input int count);
        int shape;
        int seg_left;
        int level;
        int step;
        shape    = 0;
        seg_left = 0;
        step     = 1;
        level    = $urandom_range(0, mads_pkg::LEVEL_MAX);
        for (int k = 0; k < count; k++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(4, 40);
                shape    = $urandom_range(0, 9);
                step     = $urandom_range(1, 6);
                if ($urandom_range(0, 1) == 1) begin
                    step = -step;
                end
            end
            seg_left--;
            case (shape)
                0: level = $urandom_range(0, mads_pkg::LEVEL_MAX);
                1: level = ($urandom_range(0, 1) == 1) ? mads_pkg::LEVEL_MAX : 0;
                2, 3, 4: level = level + int'($urandom_range(0, 6)) - 3;
                5, 6: level = level + step;
                7: level = $urandom_range(0, 100);
                default: level = level + (((k % 2) == 1) ? step : -step);
            endcase
            if (level < 0) begin
                level = 0;
            end else if (level > mads_pkg::LEVEL_MAX) begin
                level = mads_pkg::LEVEL_MAX;
            end
            push_sample(level);
        end
    endtask

    // One random phase: new deadband, new pacing, then a batch of traces.
    task automatic run_phase(input logic [mads_pkg::LEVEL_W-1:0] deadband, input int gaps,
                             input int bursts, input ready_mode_t mode, input int count);
        write_min_change(deadband);
        gap_max      = gaps;
        burst_max    = bursts;
        ready_mode   = mode;
        stall_period = $urandom_range(16, 64);
        stall_len    = $urandom_range(1, stall_period / 2);
        queue_levels(count);
    endtask

    // Stimulus.
    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset deadband of 2. The first sample of zero
        // leaves the held level alone, full-scale samples fill the ring while
        // the average is taken over fewer than eight entries, the ring then
        // saturates at the top of the range, and small moves of one are held
        // back by the deadband before a large drop gets through.
        ready_mode = READY_RANDOM;
        gap_max    = 2;
        burst_max  = 4;
        push_sample(0);
        for (int k = 0; k < 7; k++) begin
            push_sample(mads_pkg::LEVEL_MAX);
        end
        push_sample(mads_pkg::LEVEL_MAX);
        push_sample(mads_pkg::LEVEL_MAX - 1);
        push_sample(mads_pkg::LEVEL_MAX - 2);
        push_sample(0);
        push_sample(0);

        // Zero deadband: every average is taken, even a change of one.
        write_min_change(0);
        push_sample(1);
        push_sample(2);
        push_sample(3);
        push_sample(3);
        push_sample(0);
        push_sample(100);

        // Widest deadband: almost nothing gets past a full ring.
        write_min_change(mads_pkg::LEVEL_MAX);
        push_sample(0);
        push_sample(mads_pkg::LEVEL_MAX);
        push_sample(0);
        push_sample(mads_pkg::LEVEL_MAX);
        push_sample(128);
        push_sample(127);

        // Random phases across the deadband range, including a stretch with
        // no idling on either side. Each boundary waits for all results.
        run_phase(2,         4,  8, READY_RANDOM,   150);
        run_phase(0,         0,  1, READY_ALWAYS,   150);
        run_phase(1,        20,  3, READY_PERIODIC, 150);
        run_phase(3,         2, 16, READY_SPARSE,   150);
        run_phase(mads_pkg::LEVEL_MAX, 6,  6, READY_RANDOM,   150);
        run_phase(128,       0,  8, READY_PERIODIC, 150);
        run_phase(mads_pkg::LEVEL_W'($urandom_range(0, 16)), 10, 2, READY_RANDOM, 150);
        run_phase(mads_pkg::LEVEL_MAX - 1, 3, 12, READY_ALWAYS, 150);
        run_phase(10,       15,  4, READY_SPARSE,   150);
        run_phase(mads_pkg::LEVEL_W'($urandom_range(0, mads_pkg::LEVEL_MAX)), 5, 10,
                  READY_PERIODIC, 150);

        // Drain, then give the block time to show any stray result.
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (pending_levels.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", pending_levels.size()));
        end

        $display("Sent %0d samples over %0d deadband settings; checked %0d results.",
                 accepted_count, settings_used + 1, results_seen);
        $display("The held level moved on %0d results; %0d mismatches in total.",
                 changes_seen, error_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("Timed out with %0d results outstanding.", pending_levels.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
